/* rtl/dhfk_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dhfk_pkg: shared definitions for the DH chain forward kinematics block
// Fixed-point constants, CORDIC arctangent table, multiply-accumulate op
// descriptor, saturation and Hamilton product sign helpers.
// ----------------------------------------------------------------------------
package dhfk_pkg;

	localparam int MAX_LINKS = 8;
	localparam int IDX_W     = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
	localparam int CNT_W     = $clog2(MAX_LINKS + 1);

	localparam logic signed [31:0] ONE_Q24     = 32'sd16777216;
	localparam logic signed [33:0] TWOPI_Q24   = 34'sd105414357;
	localparam logic signed [33:0] PI_Q24      = 34'sd52707179;
	localparam logic signed [33:0] HALFPI_Q24  = 34'sd26353589;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam int CORDIC_STEPS = 30;
	localparam int RED_STEPS    = 5;

	// Multiply-accumulate op issued by the sequencer
	typedef struct packed {
		logic       vld;
		logic       neg;
		logic       shr;
		logic       first;
		logic       last;
		logic [2:0] dest;
	} mac_op_t;

	// Arctangent of 2^-i in Q2.30
	function automatic logic signed [32:0] atan_q30(input logic [4:0] i);
		logic signed [32:0] t;
		case (i)
			5'd0:    t = 33'sd843314857;
			5'd1:    t = 33'sd497837829;
			5'd2:    t = 33'sd263043837;
			5'd3:    t = 33'sd133525159;
			5'd4:    t = 33'sd67021687;
			5'd5:    t = 33'sd33543516;
			5'd6:    t = 33'sd16775851;
			5'd7:    t = 33'sd8388437;
			5'd8:    t = 33'sd4194283;
			5'd9:    t = 33'sd2097141;
			5'd10:   t = 33'sd1048575;
			5'd11:   t = 33'sd524288;
			5'd12:   t = 33'sd262144;
			5'd13:   t = 33'sd131072;
			5'd14:   t = 33'sd65536;
			5'd15:   t = 33'sd32768;
			5'd16:   t = 33'sd16384;
			5'd17:   t = 33'sd8192;
			5'd18:   t = 33'sd4096;
			5'd19:   t = 33'sd2048;
			5'd20:   t = 33'sd1024;
			5'd21:   t = 33'sd512;
			5'd22:   t = 33'sd256;
			5'd23:   t = 33'sd128;
			5'd24:   t = 33'sd64;
			5'd25:   t = 33'sd32;
			5'd26:   t = 33'sd16;
			5'd27:   t = 33'sd8;
			5'd28:   t = 33'sd4;
			5'd29:   t = 33'sd2;
			default: t = 33'sd0;
		endcase
		return t;
	endfunction

	// Clamp a wide value to 32-bit signed
	function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
		logic signed [31:0] r;
		if (v > 67'sd2147483647)
			r = 32'sh7fffffff;
		else if (v < -67'sd2147483648)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

	// Sign of term i in Hamilton product component c
	function automatic logic ham_neg(input logic [1:0] c, input logic [1:0] i);
		logic n;
		case (c)
			2'd0:    n = (i != 2'd0);
			2'd1:    n = (i == 2'd3);
			2'd2:    n = (i == 2'd1);
			default: n = (i == 2'd2);
		endcase
		return n;
	endfunction

endpackage
`default_nettype wire

/* rtl/dh_chain_forward_kinematics.sv */
`default_nettype none
// Each joint item runs two CORDIC passes on one sine/cosine unit, then 60
// multiplies on one shared multiplier; one item at a time, so no new item
// or table write is accepted until the result has been taken.
// Reset: pose returns to identity, link counter to zero; link table undefined.
// ----------------------------------------------------------------------------
// dh_chain_forward_kinematics: DH chain pose by unit dual quaternions
// Holds the link table, sequences CORDIC and the shared multiplier, and
// keeps the running pose.
// ----------------------------------------------------------------------------
module dh_chain_forward_kinematics import dhfk_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               cmd,
	input  wire logic [2:0]         link_sel,
	input  wire logic signed [31:0] angle_offset,
	input  wire logic signed [31:0] axis_offset,
	input  wire logic signed [31:0] link_length,
	input  wire logic signed [31:0] link_twist,
	input  wire logic               prismatic,
	input  wire logic signed [31:0] joint_pos,
	input  wire logic               last_link,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      real_w,
	output logic signed [31:0]      real_x,
	output logic signed [31:0]      real_y,
	output logic signed [31:0]      real_z,
	output logic signed [31:0]      dual_w,
	output logic signed [31:0]      dual_x,
	output logic signed [31:0]      dual_y,
	output logic signed [31:0]      dual_z,
	output logic                    bad_link
);

	typedef enum logic [2:0] {
		S_IDLE, S_LOAD, S_COR_H, S_COR_G, S_PROD, S_DUAL, S_POSE, S_OUT
	} st_t;

	st_t                state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [5:0]         step_q;
	logic               bad_q, last_q, out_vld_q;
	logic signed [31:0] jv_q;

	logic signed [31:0] angle_q  [MAX_LINKS];
	logic signed [31:0] axis_q   [MAX_LINKS];
	logic signed [31:0] length_q [MAX_LINKS];
	logic signed [31:0] twist_q  [MAX_LINKS];
	logic               type_q   [MAX_LINKS];

	logic signed [31:0] pose_q [8];
	logic signed [31:0] np_q   [8];
	logic signed [31:0] lk_q   [8];
	logic signed [31:0] prd_q  [4];
	logic signed [31:0] a_q, g_q, st_q, ct_q, sa_q, ca_q;
	logic signed [32:0] dd_q;

	logic               cor_start_q;
	logic signed [31:0] cor_ang_q;
	logic               cor_done;
	logic signed [31:0] cor_sin, cor_cos;

	mac_op_t            op;
	logic signed [32:0] opa, opb;
	logic               mac_done;
	logic [2:0]         mac_dest;
	logic signed [66:0] mac_acc;

	logic [IDX_W-1:0]   idx;
	logic signed [32:0] sum33;
	logic [5:0]         q6;
	logic [1:0]         pc, pi;
	logic               ph;
	logic signed [66:0] r30, r31, r16;
	logic signed [31:0] c30, l6;
	logic               in_acc, out_acc, wr_ok;

	assign idx     = cnt_q[IDX_W-1:0];
	assign in_acc  = in_valid & in_ready;
	assign out_acc = out_vld_q & out_ready;
	assign wr_ok   = ({29'd0, link_sel} < 32'(MAX_LINKS));
	assign sum33   = 33'(angle_q[idx]) + 33'(jv_q);

	dhfk_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cor_start_q),
		.angle   (cor_ang_q),
		.done    (cor_done),
		.sin_val (cor_sin),
		.cos_val (cor_cos)
	);

	dhfk_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.opa    (opa),
		.opb    (opb),
		.done   (mac_done),
		.dest   (mac_dest),
		.acc    (mac_acc)
	);

	// Pick multiplier operands for the current step
	always_comb begin
		op  = '0;
		opa = '0;
		opb = '0;
		q6  = step_q - 6'd16;
		pc  = '0;
		pi  = '0;
		ph  = 1'b0;
		case (state_q)
			S_PROD: begin
				op.vld   = (step_q < 6'd4);
				op.first = 1'b1;
				op.last  = 1'b1;
				op.dest  = {1'b0, step_q[1:0]};
				case (step_q[1:0])
					2'd0:    begin opa = 33'(ca_q); opb = 33'(ct_q); end
					2'd1:    begin opa = 33'(sa_q); opb = 33'(ct_q); end
					2'd2:    begin opa = 33'(sa_q); opb = 33'(st_q); end
					default: begin opa = 33'(ca_q); opb = 33'(st_q); end
				endcase
			end
			S_DUAL: begin
				op.vld   = (step_q < 6'd8);
				op.first = ~step_q[0];
				op.last  = step_q[0];
				op.dest  = {1'b0, step_q[2:1]};
				case (step_q[2:0])
					3'd0: begin opa = 33'(a_q); opb = 33'(prd_q[1]); op.neg = 1'b1; end
					3'd1: begin opa = dd_q;     opb = 33'(prd_q[3]); op.neg = 1'b1; end
					3'd2: begin opa = 33'(a_q); opb = 33'(prd_q[0]); end
					3'd3: begin opa = dd_q;     opb = 33'(prd_q[2]); op.neg = 1'b1; end
					3'd4: begin opa = 33'(a_q); opb = 33'(prd_q[3]); end
					3'd5: begin opa = dd_q;     opb = 33'(prd_q[1]); end
					3'd6: begin opa = dd_q;     opb = 33'(prd_q[0]); end
					default: begin opa = 33'(a_q); opb = 33'(prd_q[2]); op.neg = 1'b1; end
				endcase
			end
			S_POSE: begin
				op.vld = (step_q < 6'd48);
				op.shr = 1'b1;
				if (step_q < 6'd16) begin
					pc       = step_q[3:2];
					pi       = step_q[1:0];
					opa      = 33'(pose_q[{1'b0, pi}]);
					opb      = 33'(lk_q[{1'b0, pi ^ pc}]);
					op.first = (pi == 2'd0);
					op.last  = (pi == 2'd3);
					op.dest  = {1'b0, pc};
				end else begin
					pc       = q6[4:3];
					ph       = q6[2];
					pi       = q6[1:0];
					opa      = 33'(pose_q[{ph, pi}]);
					opb      = 33'(lk_q[{~ph, pi ^ pc}]);
					op.first = ~ph & (pi == 2'd0);
					op.last  = ph & (pi == 2'd3);
					op.dest  = {1'b1, pc};
				end
				op.neg = ham_neg(pc, pi);
			end
			default: op = '0;
		endcase
	end

	// Round accumulated sums
	always_comb begin
		r30 = (mac_acc + (67'sd1 <<< 29)) >>> 30;
		r31 = (mac_acc + (67'sd1 <<< 30)) >>> 31;
		r16 = (mac_acc + (67'sd1 <<< 15)) >>> 16;
		c30 = r30[31:0];
		l6  = (c30 + 32'sd32) >>> 6;
	end

	// Sequencer, link table and pose
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			step_q      <= '0;
			bad_q       <= 1'b0;
			last_q      <= 1'b0;
			out_vld_q   <= 1'b0;
			cor_start_q <= 1'b0;
			for (int k = 0; k < 8; k++)
				pose_q[k] <= '0;
			pose_q[0] <= ONE_Q24;
		end else begin
			cor_start_q <= 1'b0;
			// Write back finished sums
			if (mac_done) begin
				case (state_q)
					S_PROD: begin
						prd_q[mac_dest[1:0]]        <= c30;
						lk_q[{1'b0, mac_dest[1:0]}] <= l6;
					end
					S_DUAL: lk_q[{1'b1, mac_dest[1:0]}] <= sat32(r31);
					S_POSE: np_q[mac_dest] <= sat32(r16);
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (!cmd) begin
							if (wr_ok) begin
								angle_q[IDX_W'(link_sel)]  <= angle_offset;
								axis_q[IDX_W'(link_sel)]   <= axis_offset;
								length_q[IDX_W'(link_sel)] <= link_length;
								twist_q[IDX_W'(link_sel)]  <= link_twist;
								type_q[IDX_W'(link_sel)]   <= prismatic;
							end
						end else begin
							jv_q   <= joint_pos;
							last_q <= last_link;
							if (cnt_q == CNT_W'(MAX_LINKS)) begin
								bad_q     <= 1'b1;
								out_vld_q <= 1'b1;
								state_q   <= S_OUT;
							end else begin
								bad_q   <= 1'b0;
								state_q <= S_LOAD;
							end
						end
					end
				end
				S_LOAD: begin
					if (type_q[idx]) begin
						cor_ang_q <= angle_q[idx] >>> 1;
						dd_q      <= 33'(axis_q[idx]) + 33'(jv_q);
					end else begin
						cor_ang_q <= sum33[32:1];
						dd_q      <= 33'(axis_q[idx]);
					end
					g_q         <= twist_q[idx] >>> 1;
					a_q         <= length_q[idx];
					cor_start_q <= 1'b1;
					state_q     <= S_COR_H;
				end
				S_COR_H: begin
					if (cor_done) begin
						st_q        <= cor_sin;
						ct_q        <= cor_cos;
						cor_ang_q   <= g_q;
						cor_start_q <= 1'b1;
						state_q     <= S_COR_G;
					end
				end
				S_COR_G: begin
					if (cor_done) begin
						sa_q    <= cor_sin;
						ca_q    <= cor_cos;
						step_q  <= '0;
						state_q <= S_PROD;
					end
				end
				S_PROD: begin
					if (step_q == 6'd5) begin
						step_q  <= '0;
						state_q <= S_DUAL;
					end else
						step_q <= step_q + 6'd1;
				end
				S_DUAL: begin
					if (step_q == 6'd9) begin
						step_q  <= '0;
						state_q <= S_POSE;
					end else
						step_q <= step_q + 6'd1;
				end
				S_POSE: begin
					if (step_q == 6'd50) begin
						for (int k = 0; k < 8; k++)
							pose_q[k] <= np_q[k];
						cnt_q     <= cnt_q + 1'b1;
						out_vld_q <= 1'b1;
						state_q   <= S_OUT;
					end else
						step_q <= step_q + 6'd1;
				end
				S_OUT: begin
					if (out_acc) begin
						out_vld_q <= 1'b0;
						state_q   <= S_IDLE;
						// Restart the chain after the last link
						if (last_q) begin
							for (int k = 0; k < 8; k++)
								pose_q[k] <= '0;
							pose_q[0] <= ONE_Q24;
							cnt_q     <= '0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_vld_q;
	assign real_w    = pose_q[0];
	assign real_x    = pose_q[1];
	assign real_y    = pose_q[2];
	assign real_z    = pose_q[3];
	assign dual_w    = pose_q[4];
	assign dual_x    = pose_q[5];
	assign dual_y    = pose_q[6];
	assign dual_z    = pose_q[7];
	assign bad_link  = bad_q;

endmodule
`default_nettype wire

/* rtl/dhfk_cordic.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dhfk_cordic: iterative sine/cosine unit
// Reduces a Q8.24 angle into [-pi/2, pi/2] by restoring subtraction, then
// runs one CORDIC rotation step per cycle; results are Q2.30.
// ----------------------------------------------------------------------------
module dhfk_cordic import dhfk_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [31:0] angle,
	output logic                    done,
	output logic signed [31:0]      sin_val,
	output logic signed [31:0]      cos_val
);

	typedef enum logic [1:0] {C_IDLE, C_RED, C_FOLD, C_ITER} cst_t;

	cst_t               state_q;
	logic [4:0]         i_q;
	logic signed [33:0] r_q;
	logic signed [33:0] x_q, y_q;
	logic signed [32:0] z_q;
	logic               neg_q;
	logic               done_q;
	logic signed [31:0] sin_q, cos_q;

	logic signed [33:0] step_sub;
	logic signed [33:0] r_wrap, r_fold;
	logic               fold_neg;
	logic signed [33:0] dx, dy, x_nx, y_nx;
	logic signed [32:0] z_nx;

	// Restoring reduction step, quadrant fold and rotation step
	always_comb begin
		step_sub = TWOPI_Q24 <<< i_q;
		r_wrap   = (r_q > PI_Q24) ? r_q - TWOPI_Q24 : r_q;
		fold_neg = 1'b0;
		r_fold   = r_wrap;
		if (r_wrap > HALFPI_Q24) begin
			r_fold   = r_wrap - PI_Q24;
			fold_neg = 1'b1;
		end else if (r_wrap < -HALFPI_Q24) begin
			r_fold   = r_wrap + PI_Q24;
			fold_neg = 1'b1;
		end
		dx = y_q >>> i_q;
		dy = x_q >>> i_q;
		if (!z_q[32]) begin
			x_nx = x_q - dx;
			y_nx = y_q + dy;
			z_nx = z_q - atan_q30(i_q);
		end else begin
			x_nx = x_q + dx;
			y_nx = y_q - dy;
			z_nx = z_q + atan_q30(i_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				C_IDLE: begin
					if (start) begin
						// Shift negative angles up by 21 turns
						r_q     <= angle[31] ? 34'(angle) + 34'sd2213701497 : 34'(angle);
						i_q     <= 5'(RED_STEPS - 1);
						state_q <= C_RED;
					end
				end
				C_RED: begin
					if (r_q >= step_sub)
						r_q <= r_q - step_sub;
					if (i_q == 5'd0)
						state_q <= C_FOLD;
					else
						i_q <= i_q - 5'd1;
				end
				C_FOLD: begin
					z_q     <= 33'(r_fold <<< 6);
					x_q     <= CORDIC_GAIN;
					y_q     <= '0;
					neg_q   <= fold_neg;
					i_q     <= '0;
					state_q <= C_ITER;
				end
				C_ITER: begin
					x_q <= x_nx;
					y_q <= y_nx;
					z_q <= z_nx;
					i_q <= i_q + 5'd1;
					if (i_q == 5'(CORDIC_STEPS - 1)) begin
						cos_q   <= neg_q ? 32'(-x_nx) : x_nx[31:0];
						sin_q   <= neg_q ? 32'(-y_nx) : y_nx[31:0];
						done_q  <= 1'b1;
						state_q <= C_IDLE;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign done    = done_q;
	assign sin_val = sin_q;
	assign cos_val = cos_q;

endmodule
`default_nettype wire

/* rtl/dhfk_mac.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dhfk_mac: shared multiply-accumulate unit
// Registered 33x33 signed multiply, then an optional shift by 8 and a signed
// accumulate; flags the end of each group with its destination.
// ----------------------------------------------------------------------------
module dhfk_mac import dhfk_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mac_op_t            op,
	input  wire logic signed [32:0] opa,
	input  wire logic signed [32:0] opb,
	output logic                    done,
	output logic [2:0]              dest,
	output logic signed [66:0]      acc
);

	mac_op_t            op_s1;
	logic signed [65:0] prod_s1;
	logic signed [66:0] acc_q;
	logic               done_q;
	logic [2:0]         dest_q;
	logic signed [66:0] term;

	// Scale and sign the product
	always_comb begin
		term = op_s1.shr ? 67'(prod_s1 >>> 8) : 67'(prod_s1);
		if (op_s1.neg)
			term = -term;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1  <= '0;
			done_q <= 1'b0;
		end else begin
			op_s1   <= op;
			prod_s1 <= opa * opb;
			done_q  <= op_s1.vld & op_s1.last;
			dest_q  <= op_s1.dest;
			if (op_s1.vld)
				acc_q <= (op_s1.first ? 67'sd0 : acc_q) + term;
		end
	end

	assign done = done_q;
	assign dest = dest_q;
	assign acc  = acc_q;

endmodule
`default_nettype wire

/* tb/dhfk_checker.sv */
// ----------------------------------------------------------------------------
// dhfk_checker: pose predictor and scoreboard for the DH chain block
// Watches both channels, keeps its own link table and running pose, predicts
// the pose for each joint item and compares every output item field by field.
// ----------------------------------------------------------------------------
module dhfk_checker import dhfk_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire logic               cmd,
	input  wire logic [2:0]         link_sel,
	input  wire logic signed [31:0] angle_offset,
	input  wire logic signed [31:0] axis_offset,
	input  wire logic signed [31:0] link_length,
	input  wire logic signed [31:0] link_twist,
	input  wire logic               prismatic,
	input  wire logic signed [31:0] joint_pos,
	input  wire logic               last_link,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire logic signed [31:0] real_w,
	input  wire logic signed [31:0] real_x,
	input  wire logic signed [31:0] real_y,
	input  wire logic signed [31:0] real_z,
	input  wire logic signed [31:0] dual_w,
	input  wire logic signed [31:0] dual_x,
	input  wire logic signed [31:0] dual_y,
	input  wire logic signed [31:0] dual_z,
	input  wire logic               bad_link,
	output int                      fail_count,
	output int                      pending
);

	typedef struct packed {
		logic [7:0][31:0] comp;
		logic             bad;
	} pose_item_t;

	localparam longint ARCTAN [30] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097141, 1048575, 524288, 262144, 131072,
		65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
		16, 8, 4, 2};

	logic signed [31:0] theta_tbl [MAX_LINKS];
	logic signed [31:0] d_tbl     [MAX_LINKS];
	logic signed [31:0] a_tbl     [MAX_LINKS];
	logic signed [31:0] alpha_tbl [MAX_LINKS];
	logic               slide_tbl [MAX_LINKS];
	logic signed [31:0] pose      [8];
	int                 links_done;
	pose_item_t         expected_poses [$];

	function automatic longint round_shr(input longint v, input int k);
		return (v + (longint'(1) << (k - 1))) >>> k;
	endfunction

	function automatic logic signed [31:0] clamp32(input longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return v[31:0];
	endfunction

	// Fold the angle into [-pi/2, pi/2], then rotate by CORDIC in Q2.30
	function automatic void cordic_sincos(input longint ang, output longint s,
			output longint c);
		longint r, x, y, z, dx, dy;
		bit     flip;
		flip = 0;
		x = CORDIC_GAIN;
		y = 0;
		r = ang % longint'(TWOPI_Q24);
		if (r < 0)
			r += TWOPI_Q24;
		if (r > PI_Q24)
			r -= TWOPI_Q24;
		if (r > HALFPI_Q24) begin
			r -= PI_Q24;
			flip = 1;
		end else if (r < -longint'(HALFPI_Q24)) begin
			r += PI_Q24;
			flip = 1;
		end
		z = r * 64;
		for (int i = 0; i < 30; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= ARCTAN[i];
			end else begin
				x += dx;
				y -= dy;
				z += ARCTAN[i];
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		s = y;
		c = x;
	endfunction

	// Accumulate the Hamilton product p*q, each term scaled down by 2^8
	function automatic void hamilton_acc(inout longint acc [4],
			input logic signed [31:0] p [4], input logic signed [31:0] q [4]);
		longint t [4][4];
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++)
				t[i][j] = (longint'(p[i]) * longint'(q[j])) >>> 8;
		acc[0] += t[0][0] - t[1][1] - t[2][2] - t[3][3];
		acc[1] += t[0][1] + t[1][0] + t[2][3] - t[3][2];
		acc[2] += t[0][2] - t[1][3] + t[2][0] + t[3][1];
		acc[3] += t[0][3] + t[1][2] - t[2][1] + t[3][0];
	endfunction

	// Build the link dual quaternion and multiply it onto the pose
	task automatic advance_pose(input int k, input longint jv);
		longint             h, dd, a, st, ct, sa, ca, cc, sc, ss, cs;
		longint             acc_r [4], acc_d [4];
		logic signed [31:0] lr [4], ld [4], pr [4], pd [4];
		dd = d_tbl[k];
		a = a_tbl[k];
		if (slide_tbl[k]) begin
			h = longint'(theta_tbl[k]) >>> 1;
			dd += jv;
		end else begin
			h = (longint'(theta_tbl[k]) + jv) >>> 1;
		end
		cordic_sincos(h, st, ct);
		cordic_sincos(longint'(alpha_tbl[k]) >>> 1, sa, ca);
		cc = round_shr(ca * ct, 30);
		sc = round_shr(sa * ct, 30);
		ss = round_shr(sa * st, 30);
		cs = round_shr(ca * st, 30);
		lr[0] = clamp32(round_shr(cc, 6));
		lr[1] = clamp32(round_shr(sc, 6));
		lr[2] = clamp32(round_shr(ss, 6));
		lr[3] = clamp32(round_shr(cs, 6));
		ld[0] = clamp32(round_shr(-a * sc - dd * cs, 31));
		ld[1] = clamp32(round_shr(a * cc - dd * ss, 31));
		ld[2] = clamp32(round_shr(a * cs + dd * sc, 31));
		ld[3] = clamp32(round_shr(dd * cc - a * ss, 31));
		for (int i = 0; i < 4; i++) begin
			pr[i] = pose[i];
			pd[i] = pose[4 + i];
			acc_r[i] = 0;
			acc_d[i] = 0;
		end
		hamilton_acc(acc_r, pr, lr);
		hamilton_acc(acc_d, pr, ld);
		hamilton_acc(acc_d, pd, lr);
		for (int i = 0; i < 4; i++) begin
			pose[i] = clamp32(round_shr(acc_r[i], 16));
			pose[4 + i] = clamp32(round_shr(acc_d[i], 16));
		end
	endtask

	task automatic reset_pose();
		for (int i = 0; i < 8; i++)
			pose[i] = '0;
		pose[0] = ONE_Q24;
		links_done = 0;
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	// Compare the output item first, then take the input item
	always @(posedge clk or negedge arst_n) begin
		pose_item_t       want;
		logic [7:0][31:0] got;
		if (!arst_n) begin
			reset_pose();
			expected_poses.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				got = {dual_z, dual_y, dual_x, dual_w, real_z, real_y, real_x, real_w};
				if (expected_poses.size() == 0) begin
					report_mismatch("unexpected item", got[0], '0);
				end else begin
					want = expected_poses.pop_front();
					for (int i = 0; i < 8; i++)
						if (got[i] !== want.comp[i])
							report_mismatch($sformatf("pose component %0d", i),
								got[i], want.comp[i]);
					if (bad_link !== want.bad)
						report_mismatch("bad_link", bad_link, want.bad);
				end
			end
			if (in_valid && in_ready) begin
				if (!cmd) begin
					if (link_sel < MAX_LINKS) begin
						theta_tbl[link_sel] = angle_offset;
						d_tbl[link_sel] = axis_offset;
						a_tbl[link_sel] = link_length;
						alpha_tbl[link_sel] = link_twist;
						slide_tbl[link_sel] = prismatic;
					end
				end else begin
					want.bad = (links_done >= MAX_LINKS);
					if (!want.bad) begin
						advance_pose(links_done, longint'(joint_pos));
						links_done++;
					end
					for (int i = 0; i < 8; i++)
						want.comp[i] = pose[i];
					expected_poses.insert(expected_poses.size(), want);
					if (last_link)
						reset_pose();
				end
			end
			pending = expected_poses.size();
		end
	end

endmodule

/* tb/tb_dh_chain_forward_kinematics.sv */
// ----------------------------------------------------------------------------
// tb_dh_chain_forward_kinematics: stimulus and verdict for the DH chain block
// Fills the link table, runs directed chains at the field extremes and a
// full table, then random chains with bursty idling and one long output hold.
// ----------------------------------------------------------------------------
module tb_dh_chain_forward_kinematics import dhfk_pkg::*;;

	localparam int RANDOM_ITEMS = 1200;
	localparam int QUIET_TAIL   = 150;
	localparam int STALL_LIMIT  = 5000;
	localparam logic signed [31:0] QMAX = 32'sh7fffffff;
	localparam logic signed [31:0] QMIN = 32'sh80000000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               cmd;
	logic [2:0]         link_sel;
	logic signed [31:0] angle_offset;
	logic signed [31:0] axis_offset;
	logic signed [31:0] link_length;
	logic signed [31:0] link_twist;
	logic               prismatic;
	logic signed [31:0] joint_pos;
	logic               last_link;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] real_w, real_x, real_y, real_z;
	logic signed [31:0] dual_w, dual_x, dual_y, dual_z;
	logic               bad_link;
	int                 fail_count;
	int                 pending;
	int                 items_sent;
	bit                 idle_on;
	bit                 hold_done;

	dh_chain_forward_kinematics DUT (.*);

	dhfk_checker pose_check (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// End the run when neither channel moves for too long
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("FAIL dh_chain_forward_kinematics");
				$finish;
			end
		end
	end

	// Output side: random stall bursts and one long hold
	initial begin
		int n;
		out_ready = 0;
		hold_done = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!hold_done && items_sent >= 300) begin
				hold_done = 1;
				out_ready = 0;
				repeat (600) @(negedge clk);
			end
			if (idle_on && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 19);
				out_ready = 0;
				repeat (n - 1) @(negedge clk);
			end else begin
				out_ready = 1;
			end
		end
	end

	function automatic logic signed [31:0] pick_q();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 2 ** 27)) - 2 ** 26);
			2: return 32'($signed($urandom_range(0, 2 ** 25)) - 2 ** 24);
			default: return 32'($signed($urandom_range(0, 2 ** 30)) - 2 ** 29);
		endcase
	endfunction

	// Offer one item from a falling edge and hold it until accepted
	task automatic send_item(input logic c, input logic [2:0] sel,
			input logic signed [31:0] th, input logic signed [31:0] d,
			input logic signed [31:0] a, input logic signed [31:0] al,
			input logic pr, input logic signed [31:0] jv, input logic lst);
		int n;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 19);
			in_valid = 0;
			repeat (n) @(negedge clk);
		end
		cmd = c;
		link_sel = sel;
		angle_offset = th;
		axis_offset = d;
		link_length = a;
		link_twist = al;
		prismatic = pr;
		joint_pos = jv;
		last_link = lst;
		in_valid = 1;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic write_link(input logic [2:0] sel, input logic signed [31:0] th,
			input logic signed [31:0] d, input logic signed [31:0] a,
			input logic signed [31:0] al, input logic pr);
		send_item(1'b0, sel, th, d, a, al, pr, $urandom, 1'($urandom_range(0, 1)));
	endtask

	task automatic send_joint(input logic signed [31:0] jv, input logic lst);
		send_item(1'b1, 3'($urandom), $urandom, $urandom, $urandom, $urandom,
			1'($urandom_range(0, 1)), jv, lst);
	endtask

	initial begin
		in_valid = 0;
		cmd = 0;
		link_sel = '0;
		angle_offset = '0;
		axis_offset = '0;
		link_length = '0;
		link_twist = '0;
		prismatic = 0;
		joint_pos = '0;
		last_link = 0;
		items_sent = 0;
		idle_on = 0;
		arst_n = 0;
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: fill every entry with extremes, both joint types
		write_link(3'd0, '0, '0, '0, '0, 1'b0);
		write_link(3'd1, QMAX, QMIN, QMAX, QMIN, 1'b0);
		write_link(3'd2, QMIN, QMAX, QMIN, QMAX, 1'b1);
		write_link(3'd3, 32'sd26353589, 32'sd16777216, 32'sd16777216, 32'sd52707179,
			1'b0);
		write_link(3'd4, -32'sd52707179, QMAX, QMAX, -32'sd26353589, 1'b1);
		write_link(3'd5, 32'sd105414357, QMIN, QMIN, 32'sd105414357, 1'b0);
		write_link(3'd6, QMAX, QMAX, QMAX, QMAX, 1'b1);
		write_link(3'd7, QMIN, QMIN, QMIN, QMIN, 1'b0);
		send_joint('0, 1'b1);
		send_joint(QMAX, 1'b0);
		send_joint(QMIN, 1'b0);
		send_joint(QMAX, 1'b1);
		// Full table: eight links, a flagged ninth, then a flagged last one
		for (int i = 0; i < 8; i++)
			send_joint(pick_q(), 1'b0);
		send_joint(QMIN, 1'b0);
		send_joint(QMAX, 1'b1);

		// Random chains with table rewrites between and within them
		idle_on = 1;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS - QUIET_TAIL)
				idle_on = 0;
			if ($urandom_range(0, 6) == 0)
				write_link(3'($urandom), pick_q(), pick_q(), pick_q(), pick_q(),
					1'($urandom_range(0, 1)));
			else
				send_joint(pick_q(), $urandom_range(0, 5) == 0);
		end
		in_valid = 0;
		idle_on = 0;

		while (pending != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("PASS dh_chain_forward_kinematics");
		else
			$display("FAIL dh_chain_forward_kinematics");
		$finish;
	end

endmodule
